[rtl/ibt_pkg.sv]
`default_nettype none
package ibt_pkg;
   localparam int ENTRIES  = 64;
   localparam int KEY_BITS = 16;
   localparam int IDX_W    = $clog2(ENTRIES);
   localparam int CNT_W    = $clog2(ENTRIES + 1);

   localparam logic [2:0] ST_INSERTED  = 3'd0;
   localparam logic [2:0] ST_TIGHTENED = 3'd1;
   localparam logic [2:0] ST_REDUNDANT = 3'd2;
   localparam logic [2:0] ST_CONFLICT  = 3'd3;
   localparam logic [2:0] ST_DELETED   = 3'd4;
   localparam logic [2:0] ST_NOTFOUND  = 3'd5;
   localparam logic [2:0] ST_FULL      = 3'd6;

   localparam logic KIND_ADD = 1'b0;

   typedef struct packed {
      logic capture;
      logic search;
      logic decide;
      logic apply;
   } ctl_cmd_type;
endpackage
`default_nettype wire

[rtl/ibt_datapath.sv]
`default_nettype none
module ibt_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire ibt_pkg::ctl_cmd_type       cmd,
   input  wire logic                       req_kind,
   input  wire logic                       req_side,
   input  wire logic [15:0]                req_var_index,
   input  wire logic                       req_var_is_binary,
   input  wire logic                       req_bound_kind,
   input  wire logic signed [31:0]         req_bound_value,
   input  wire logic                       tol_write,
   input  wire logic [15:0]                tol_data,
   output logic [2:0]                      rsp_status,
   output logic [31:0]                     rsp_entry_id,
   output logic [6:0]                      rsp_side_count
);
   import ibt_pkg::*;

   logic [KEY_BITS-1:0] key_ff   [2][ENTRIES];
   logic                upper_ff [2][ENTRIES];
   logic [31:0]         bound_ff [2][ENTRIES];
   logic [31:0]         tag_ff   [2][ENTRIES];
   logic [KEY_BITS-1:0] key_in   [2][ENTRIES];
   logic                upper_in [2][ENTRIES];
   logic [31:0]         bound_in [2][ENTRIES];
   logic [31:0]         tag_in   [2][ENTRIES];

   logic [CNT_W-1:0] used_ff [2];
   logic [CNT_W-1:0] bcnt_ff [2];
   logic [31:0]      next_tag_ff;
   logic [15:0]      tol_ff;

   // Captured item.
   logic                it_kind_ff, it_side_ff, it_bin_ff, it_upper_ff;
   logic [KEY_BITS-1:0] it_key_ff;
   logic [31:0]         it_bound_ff;

   // Search results.
   logic               has_lo_ff, has_up_ff, has_lo_in, has_up_in;
   logic [31:0]        blo_ff, bup_ff, blo_in, bup_in;
   logic [IDX_W-1:0]   at_ff, at_in;
   logic [ENTRIES-1:0] gepos_ff, gepos_in;

   // Decision.
   logic [2:0] status_ff, status_in;
   logic       do_ins_ff, do_tight_ff, do_del_ff;
   logic       do_ins_in, do_tight_in, do_del_in;

   logic [2:0]       rsp_status_ff;
   logic [31:0]      rsp_id_ff;
   logic [CNT_W-1:0] rsp_count_ff;

   logic [CNT_W-1:0] used_cur, bc_cur, lo_b, hi_b;

   always_comb begin
      logic [IDX_W-1:0] idx_lo, idx_up;
      logic inr, less, mlo, mup;
      used_cur = used_ff[it_side_ff];
      bc_cur   = (bcnt_ff[it_side_ff] > used_cur) ? used_cur : bcnt_ff[it_side_ff];
      lo_b     = it_bin_ff ? '0 : bc_cur;
      hi_b     = it_bin_ff ? bc_cur : used_cur;
      has_lo_in = 1'b0;
      has_up_in = 1'b0;
      blo_in = '0;
      bup_in = '0;
      idx_lo = '0;
      idx_up = '0;
      for (int i = 0; i < ENTRIES; i++) begin
         inr  = (CNT_W'(i) >= lo_b) && (CNT_W'(i) < hi_b);
         less = (key_ff[it_side_ff][i] < it_key_ff) ||
                ((key_ff[it_side_ff][i] == it_key_ff) &&
                 (!upper_ff[it_side_ff][i] && it_upper_ff));
         mlo  = inr && (key_ff[it_side_ff][i] == it_key_ff) && !upper_ff[it_side_ff][i];
         mup  = inr && (key_ff[it_side_ff][i] == it_key_ff) && upper_ff[it_side_ff][i];
         has_lo_in = has_lo_in | mlo;
         has_up_in = has_up_in | mup;
         blo_in = blo_in | (mlo ? bound_ff[it_side_ff][i] : 32'd0);
         bup_in = bup_in | (mup ? bound_ff[it_side_ff][i] : 32'd0);
         idx_lo = idx_lo | (mlo ? IDX_W'(i) : '0);
         idx_up = idx_up | (mup ? IDX_W'(i) : '0);
         gepos_in[i] = (CNT_W'(i) >= lo_b) && !(inr && less);
      end
      at_in = it_upper_ff ? idx_up : idx_lo;
   end

   always_comb begin
      logic signed [33:0] bx, dlo, dup, t;
      logic red, con, same, has;
      bx  = {{2{it_bound_ff[31]}}, it_bound_ff};
      dlo = bx - {{2{blo_ff[31]}}, blo_ff};
      dup = bx - {{2{bup_ff[31]}}, bup_ff};
      t   = {18'd0, tol_ff};
      if (!it_upper_ff) begin
         red  = has_lo_ff && (dlo <= t);
         con  = has_up_ff && (dup > t);
         same = has_lo_ff;
      end else begin
         red  = has_up_ff && (dup >= -t);
         con  = has_lo_ff && (dlo < -t);
         same = has_up_ff;
      end
      has = it_upper_ff ? has_up_ff : has_lo_ff;
      do_ins_in = 1'b0;
      do_tight_in = 1'b0;
      do_del_in = 1'b0;
      if (it_kind_ff != KIND_ADD) begin
         status_in = has ? ST_DELETED : ST_NOTFOUND;
         do_del_in = has;
      end else if (red) begin
         status_in = ST_REDUNDANT;
      end else if (con) begin
         status_in = ST_CONFLICT;
      end else if (same) begin
         status_in = ST_TIGHTENED;
         do_tight_in = 1'b1;
      end else if (used_cur >= CNT_W'(ENTRIES)) begin
         status_in = ST_FULL;
      end else begin
         status_in = ST_INSERTED;
         do_ins_in = 1'b1;
      end
   end

   always_comb begin
      for (int s = 0; s < 2; s++) begin
         for (int i = 0; i < ENTRIES; i++) begin
            key_in[s][i]   = key_ff[s][i];
            upper_in[s][i] = upper_ff[s][i];
            bound_in[s][i] = bound_ff[s][i];
            tag_in[s][i]   = tag_ff[s][i];
            if (cmd.apply && (s == int'(it_side_ff))) begin
               if (do_ins_ff && gepos_ff[i]) begin
                  if (i > 0 && gepos_ff[(i > 0) ? i - 1 : 0]) begin
                     key_in[s][i]   = key_ff[s][(i > 0) ? i - 1 : 0];
                     upper_in[s][i] = upper_ff[s][(i > 0) ? i - 1 : 0];
                     bound_in[s][i] = bound_ff[s][(i > 0) ? i - 1 : 0];
                     tag_in[s][i]   = tag_ff[s][(i > 0) ? i - 1 : 0];
                  end else begin
                     key_in[s][i]   = it_key_ff;
                     upper_in[s][i] = it_upper_ff;
                     bound_in[s][i] = it_bound_ff;
                     tag_in[s][i]   = next_tag_ff;
                  end
               end
               if (do_del_ff && (IDX_W'(i) >= at_ff) && (i < ENTRIES - 1)) begin
                  key_in[s][i]   = key_ff[s][(i < ENTRIES - 1) ? i + 1 : i];
                  upper_in[s][i] = upper_ff[s][(i < ENTRIES - 1) ? i + 1 : i];
                  bound_in[s][i] = bound_ff[s][(i < ENTRIES - 1) ? i + 1 : i];
                  tag_in[s][i]   = tag_ff[s][(i < ENTRIES - 1) ? i + 1 : i];
               end
               if (do_tight_ff && (IDX_W'(i) == at_ff)) begin
                  bound_in[s][i] = it_bound_ff;
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      key_ff   <= key_in;
      upper_ff <= upper_in;
      bound_ff <= bound_in;
      tag_ff   <= tag_in;
      if (cmd.capture) begin
         it_kind_ff  <= req_kind;
         it_side_ff  <= req_side;
         it_key_ff   <= req_var_index[KEY_BITS-1:0];
         it_bin_ff   <= req_var_is_binary;
         it_upper_ff <= req_bound_kind;
         it_bound_ff <= req_bound_value;
      end
      if (cmd.search) begin
         has_lo_ff <= has_lo_in;
         has_up_ff <= has_up_in;
         blo_ff    <= blo_in;
         bup_ff    <= bup_in;
         at_ff     <= at_in;
         gepos_ff  <= gepos_in;
      end
      if (cmd.decide) begin
         status_ff   <= status_in;
         do_ins_ff   <= do_ins_in;
         do_tight_ff <= do_tight_in;
         do_del_ff   <= do_del_in;
      end
      if (reset) begin
         used_ff     <= '{default: '0};
         bcnt_ff     <= '{default: '0};
         next_tag_ff <= '0;
         tol_ff      <= 16'd1;
      end else begin
         if (tol_write) begin
            tol_ff <= tol_data;
         end
         if (cmd.apply) begin
            rsp_status_ff <= status_ff;
            rsp_id_ff     <= do_ins_ff ? next_tag_ff : 32'd0;
            rsp_count_ff  <= do_ins_ff ? used_cur + 1'b1 :
                             (do_del_ff ? used_cur - 1'b1 : used_cur);
            if (do_ins_ff) begin
               used_ff[it_side_ff] <= used_cur + 1'b1;
               next_tag_ff         <= next_tag_ff + 32'd1;
               if (it_bin_ff) begin
                  bcnt_ff[it_side_ff] <= bcnt_ff[it_side_ff] + 1'b1;
               end
            end
            if (do_del_ff) begin
               used_ff[it_side_ff] <= used_cur - 1'b1;
               if (it_bin_ff && (bcnt_ff[it_side_ff] != '0)) begin
                  bcnt_ff[it_side_ff] <= bcnt_ff[it_side_ff] - 1'b1;
               end
            end
         end
      end
   end

   assign rsp_status     = rsp_status_ff;
   assign rsp_entry_id   = rsp_id_ff;
   assign rsp_side_count = 7'(rsp_count_ff);
endmodule
`default_nettype wire

[rtl/ibt_controller.sv]
`default_nettype none
module ibt_controller (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 req_valid,
   output logic                      req_stall,
   output logic                      rsp_valid,
   input  wire logic                 rsp_stall,
   output ibt_pkg::ctl_cmd_type      cmd
);
   import ibt_pkg::*;

   typedef enum logic [1:0] {S_IDLE, S_SEARCH, S_DECIDE, S_APPLY} state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;

   always_comb begin
      state_in     = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd          = '0;
      unique case (state_ff)
         S_IDLE: begin
            cmd.capture = req_valid;
            if (req_valid) state_in = S_SEARCH;
         end
         S_SEARCH: begin
            cmd.search = 1'b1;
            state_in   = S_DECIDE;
         end
         S_DECIDE: begin
            cmd.decide = 1'b1;
            state_in   = S_APPLY;
         end
         S_APPLY: begin
            // The result register must be free before the item is committed.
            if (!rsp_valid_ff || !rsp_stall) begin
               cmd.apply    = 1'b1;
               rsp_valid_in = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign req_stall = (state_ff != S_IDLE);
   assign rsp_valid = rsp_valid_ff;
endmodule
`default_nettype wire

[rtl/implication_bound_table_unit.sv]
`default_nettype none
// Keeps two sorted tables of implied bounds, one for each side, up to 64 entries
// each, held in a row of register cells that are compared with the item key all at
// once and shifted all together. Every item passes from acceptance to its result
// through capture, parallel search of the cells, tolerance comparison and
// decision, then the table update together with loading the result register. One
// item is in work at a time; a result waiting in the output register holds the
// next item back only at its final step. The tolerance register may be written at
// any time the block is idle and resets to one.
module implication_bound_table_unit (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               req_valid,
   output logic                    req_stall,
   input  wire logic               req_kind,
   input  wire logic               req_side,
   input  wire logic [15:0]        req_var_index,
   input  wire logic               req_var_is_binary,
   input  wire logic               req_bound_kind,
   input  wire logic signed [31:0] req_bound_value,
   output logic                    rsp_valid,
   input  wire logic               rsp_stall,
   output logic [2:0]              rsp_status,
   output logic [31:0]             rsp_entry_id,
   output logic [6:0]              rsp_side_count,
   input  wire logic               csr_valid,
   output logic                    csr_ready,
   input  wire logic [15:0]        csr_feas_tolerance
);
   import ibt_pkg::*;

   ctl_cmd_type cmd;

   assign csr_ready = 1'b1;

   ibt_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   ibt_datapath u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .req_kind          (req_kind),
      .req_side          (req_side),
      .req_var_index     (req_var_index),
      .req_var_is_binary (req_var_is_binary),
      .req_bound_kind    (req_bound_kind),
      .req_bound_value   (req_bound_value),
      .tol_write         (csr_valid && csr_ready),
      .tol_data          (csr_feas_tolerance),
      .rsp_status        (rsp_status),
      .rsp_entry_id      (rsp_entry_id),
      .rsp_side_count    (rsp_side_count)
   );
endmodule
`default_nettype wire

[tb/testbench.sv]
`default_nettype none
module testbench;
   import ibt_pkg::*;

   localparam int CAP = ENTRIES;

   typedef struct {
      logic        kind;
      logic        side;
      logic [15:0] var_index;
      logic        is_bin;
      logic        upper;
      logic [31:0] bound;
   } bound_item_type;

   typedef struct {
      logic [2:0]  status;
      logic [31:0] entry_id;
      logic [6:0]  count;
   } bound_rsp_type;

   typedef struct {
      bound_item_type item;
      logic           fixed;
      bound_rsp_type  want;
   } plan_row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic        req_valid = 1'b0;
   wire         req_stall;
   logic        req_kind = 1'b0;
   logic        req_side = 1'b0;
   logic [15:0] req_var_index = '0;
   logic        req_var_is_binary = 1'b0;
   logic        req_bound_kind = 1'b0;
   logic signed [31:0] req_bound_value = '0;
   wire         rsp_valid;
   logic        rsp_stall = 1'b0;
   wire  [2:0]  rsp_status;
   wire  [31:0] rsp_entry_id;
   wire  [6:0]  rsp_side_count;
   logic        csr_valid = 1'b0;
   wire         csr_ready;
   logic [15:0] csr_feas_tolerance = '0;

   implication_bound_table_unit dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_kind(req_kind),
      .req_side(req_side), .req_var_index(req_var_index),
      .req_var_is_binary(req_var_is_binary), .req_bound_kind(req_bound_kind),
      .req_bound_value(req_bound_value),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_status(rsp_status),
      .rsp_entry_id(rsp_entry_id), .rsp_side_count(rsp_side_count),
      .csr_valid(csr_valid), .csr_ready(csr_ready),
      .csr_feas_tolerance(csr_feas_tolerance)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // Shadow copy of both tables.
   logic [15:0] tbl_key   [2][CAP];
   logic        tbl_upper [2][CAP];
   logic [31:0] tbl_bound [2][CAP];
   logic [31:0] tbl_tag   [2][CAP];
   int          tbl_used  [2];
   int          tbl_bin   [2];
   logic [31:0] tag_next;
   logic [15:0] tolerance;

   bound_rsp_type pending_rsp[$];
   int          mismatches = 0;
   int          rsp_seen = 0;
   int          status_hits[7];
   int          sent = 0;
   bit          sink_long = 1'b0;

   function automatic bound_rsp_type predict_bound(bound_item_type it);
      bound_rsp_type r;
      int s, lo, hi, pos, pl, pu, at, j;
      bit has_lo, has_up, redundant, conflict, same;
      longint b, tol, d;
      s = it.side;
      lo = it.is_bin ? 0 : tbl_bin[s];
      hi = it.is_bin ? tbl_bin[s] : tbl_used[s];
      pos = lo; pl = 0; pu = 0; has_lo = 0; has_up = 0;
      b = longint'($signed(it.bound));
      tol = longint'(tolerance);
      r.status = ST_INSERTED; r.entry_id = '0;
      for (int i = lo; i < hi; i++) begin
         if (tbl_key[s][i] == it.var_index) begin
            if (tbl_upper[s][i]) begin
               has_up = 1; pu = i;
            end else begin
               has_lo = 1; pl = i;
            end
         end
         if (tbl_key[s][i] < it.var_index ||
             (tbl_key[s][i] == it.var_index && tbl_upper[s][i] < it.upper))
            pos = i + 1;
      end
      if (it.kind != KIND_ADD) begin
         at = it.upper ? pu : pl;
         if (!(it.upper ? has_up : has_lo)) begin
            r.status = ST_NOTFOUND;
         end else begin
            for (j = at; j + 1 < tbl_used[s]; j++) begin
               tbl_key[s][j] = tbl_key[s][j+1];
               tbl_upper[s][j] = tbl_upper[s][j+1];
               tbl_bound[s][j] = tbl_bound[s][j+1];
               tbl_tag[s][j] = tbl_tag[s][j+1];
            end
            tbl_used[s]--;
            if (it.is_bin && tbl_bin[s] > 0) tbl_bin[s]--;
            r.status = ST_DELETED;
         end
      end else begin
         if (!it.upper) begin
            d = b - longint'($signed(tbl_bound[s][pl]));
            redundant = has_lo && d <= tol;
            d = b - longint'($signed(tbl_bound[s][pu]));
            conflict = has_up && d > tol;
            same = has_lo; at = pl;
         end else begin
            d = b - longint'($signed(tbl_bound[s][pu]));
            redundant = has_up && d >= -tol;
            d = b - longint'($signed(tbl_bound[s][pl]));
            conflict = has_lo && d < -tol;
            same = has_up; at = pu;
         end
         if (redundant) r.status = ST_REDUNDANT;
         else if (conflict) r.status = ST_CONFLICT;
         else if (same) begin
            tbl_bound[s][at] = it.bound;
            r.status = ST_TIGHTENED;
         end else if (tbl_used[s] >= CAP) r.status = ST_FULL;
         else begin
            for (j = tbl_used[s]; j > pos; j--) begin
               tbl_key[s][j] = tbl_key[s][j-1];
               tbl_upper[s][j] = tbl_upper[s][j-1];
               tbl_bound[s][j] = tbl_bound[s][j-1];
               tbl_tag[s][j] = tbl_tag[s][j-1];
            end
            tbl_key[s][pos] = it.var_index;
            tbl_upper[s][pos] = it.upper;
            tbl_bound[s][pos] = it.bound;
            tbl_tag[s][pos] = tag_next;
            r.entry_id = tag_next;
            tag_next++;
            if (it.is_bin) tbl_bin[s]++;
            tbl_used[s]++;
         end
      end
      r.count = 7'(tbl_used[s]);
      return r;
   endfunction

   // Valid stays high from one item to the next when no gap is drawn.
   task automatic offer_item(bound_item_type it, logic fixed, bound_rsp_type want);
      bound_rsp_type r;
      int gap;
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 18);
      if ($urandom_range(0, 2) == 0) gap = 0;
      if (gap != 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_kind <= it.kind;
      req_side <= it.side;
      req_var_index <= it.var_index;
      req_var_is_binary <= it.is_bin;
      req_bound_kind <= it.upper;
      req_bound_value <= it.bound;
      req_valid <= 1'b1;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      r = predict_bound(it);
      if (fixed && (r.status !== want.status || r.entry_id !== want.entry_id ||
                    r.count !== want.count)) begin
         mismatches++;
         if (mismatches <= 10)
            $display("table row disagrees with shadow: row %0d/%h/%0d shadow %0d/%h/%0d",
                     want.status, want.entry_id, want.count,
                     r.status, r.entry_id, r.count);
      end
      pending_rsp.push_back(r);
      sent++;
      @(negedge clock);
   endtask

   task automatic write_tolerance(logic [15:0] v);
      // The block holds one item at most, so this wait covers any work left.
      repeat (8) @(negedge clock);
      csr_feas_tolerance <= v;
      csr_valid <= 1'b1;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      tolerance = v;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain;
      int guard;
      guard = 0;
      req_valid <= 1'b0;
      while (pending_rsp.size() != 0 && guard < 100000) begin
         @(negedge clock);
         guard++;
      end
   endtask

   function automatic bound_item_type mk(int k, int s, logic [15:0] v, int bn,
                                         int u, logic [31:0] b);
      bound_item_type it;
      it.kind = 1'(k); it.side = 1'(s); it.var_index = v; it.is_bin = 1'(bn);
      it.upper = 1'(u); it.bound = b;
      return it;
   endfunction

   function automatic bound_rsp_type rs(logic [2:0] st, logic [31:0] id, int c);
      bound_rsp_type r;
      r.status = st; r.entry_id = id; r.count = 7'(c);
      return r;
   endfunction

   // Random content drawn from a small key pool so that keys collide often.
   function automatic bound_item_type rand_item(int pool);
      bound_item_type it;
      it.kind = ($urandom_range(0, 9) < 3);
      it.side = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 5))
         0: it.var_index = 16'($urandom());
         1: it.var_index = 16'hFFF0 | 16'($urandom_range(0, 15));
         default: it.var_index = 16'($urandom_range(0, pool));
      endcase
      it.is_bin = (it.var_index[0] ^ it.var_index[3]) ? 1'b1 : 1'b0;
      if ($urandom_range(0, 15) == 0) it.is_bin = ~it.is_bin;
      it.upper = 1'($urandom_range(0, 1));
      case ($urandom_range(0, 4))
         0: it.bound = $urandom();
         1: it.bound = $urandom_range(0, 1) ? 32'h7FFFFFFF : 32'h80000000;
         default: it.bound = 32'($signed($urandom_range(0, 400)) - 200);
      endcase
      return it;
   endfunction

   initial begin : stimulus
      plan_row_type plan[$];
      bound_item_type it;
      bound_rsp_type none;
      none = rs(ST_INSERTED, 0, 0);
      for (int s = 0; s < 2; s++) begin
         tbl_used[s] = 0; tbl_bin[s] = 0;
         for (int i = 0; i < CAP; i++) begin
            tbl_key[s][i] = '0; tbl_upper[s][i] = 0;
            tbl_bound[s][i] = '0; tbl_tag[s][i] = '0;
         end
      end
      tag_next = '0;
      tolerance = 16'd1;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      plan = '{
         '{mk(1, 0, 16'd5, 0, 0, 0), 1, rs(ST_NOTFOUND, 0, 0)},
         '{mk(0, 0, 16'd5, 0, 0, 32'h80000000), 1, rs(ST_INSERTED, 0, 1)},
         '{mk(0, 0, 16'd5, 0, 1, 32'h7FFFFFFF), 1, rs(ST_INSERTED, 1, 2)},
         '{mk(0, 1, 16'hFFFF, 1, 1, 32'h00010000), 1, rs(ST_INSERTED, 2, 1)},
         '{mk(0, 1, 16'd0, 1, 0, 32'h0), 1, rs(ST_INSERTED, 3, 2)},
         '{mk(0, 1, 16'd0, 1, 0, 32'h1), 1, rs(ST_REDUNDANT, 0, 2)},
         '{mk(0, 1, 16'd0, 1, 0, 32'h2), 0, none},
         '{mk(0, 1, 16'hFFFF, 1, 0, 32'h00010002), 1, rs(ST_CONFLICT, 0, 2)},
         '{mk(0, 1, 16'hFFFF, 1, 1, 32'h00010001), 1, rs(ST_REDUNDANT, 0, 2)},
         '{mk(0, 1, 16'hFFFF, 1, 1, 32'h00008000), 0, none},
         '{mk(0, 0, 16'd5, 0, 1, 32'h80000000), 0, none},
         '{mk(0, 0, 16'd5, 0, 0, 32'h7FFFFFFF), 0, none},
         '{mk(0, 0, 16'd3, 1, 1, 32'h0), 0, none},
         '{mk(0, 0, 16'hFFFF, 0, 0, 32'hFFFF0000), 0, none},
         '{mk(1, 0, 16'd5, 0, 0, 0), 0, none},
         '{mk(1, 0, 16'd5, 0, 0, 0), 0, none},
         '{mk(1, 1, 16'd0, 1, 0, 32'hFFFFFFFF), 0, none},
         '{mk(1, 1, 16'hFFFF, 0, 1, 0), 0, none},
         '{mk(0, 1, 16'h8000, 0, 1, 32'h12345678), 0, none}
      };
      foreach (plan[i]) offer_item(plan[i].item, plan[i].fixed, plan[i].want);
      drain();

      // Fill side 0 to capacity, then keep pushing inserts against the limit.
      write_tolerance(16'd0);
      for (int i = 0; i < CAP + 6; i++)
         offer_item(mk(0, 0, 16'(1000 + i), int'(i[0]), 0, 32'(i)), 0, none);
      // Sender pauses until the block has caught up.
      drain();
      write_tolerance(16'hFFFF);

      for (int phase = 0; phase < 5; phase++) begin
         if (phase == 1) sink_long = 1'b1;
         for (int n = 0; n < 230; n++) begin
            it = rand_item(phase == 2 ? 8 : 40);
            offer_item(it, 0, none);
         end
         drain();
         case (phase)
            0: write_tolerance(16'd0);
            1: write_tolerance(16'($urandom_range(1, 300)));
            2: write_tolerance(16'd1);
            default: write_tolerance(16'($urandom()));
         endcase
      end
      drain();
      repeat (20) @(negedge clock);
      $display("Sent %0d items, checked %0d results; %0d inserted, %0d tightened,",
               sent, rsp_seen, status_hits[0], status_hits[1]);
      $display("%0d redundant, %0d conflict, %0d deleted, %0d not found, %0d full.",
               status_hits[2], status_hits[3], status_hits[4], status_hits[5],
               status_hits[6]);
      if (mismatches == 0 && pending_rsp.size() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

   // Receiver side: random stall with one long hold-off once requested.
   initial begin : sink
      int wait_n;
      bit long_done;
      long_done = 0;
      forever begin
         @(negedge clock);
         if (sink_long && !long_done) begin
            long_done = 1;
            rsp_stall <= 1'b1;
            repeat (200) @(negedge clock);
            rsp_stall <= 1'b0;
         end else if ($urandom_range(0, 3) == 0) begin
            wait_n = $urandom_range(0, 18);
            if (wait_n != 0) begin
               rsp_stall <= 1'b1;
               repeat (wait_n) @(negedge clock);
               rsp_stall <= 1'b0;
            end
         end else begin
            repeat ($urandom_range(0, 12)) @(negedge clock);
         end
      end
   end

   always @(posedge clock) begin
      bound_rsp_type w;
      if (!reset && rsp_valid && !rsp_stall) begin
         rsp_seen++;
         if (pending_rsp.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("Unexpected result: status %0d id %h count %0d",
                        rsp_status, rsp_entry_id, rsp_side_count);
         end else begin
            w = pending_rsp.pop_front();
            if (w.status <= ST_FULL) status_hits[w.status]++;
            if (rsp_status !== w.status || rsp_entry_id !== w.entry_id ||
                rsp_side_count !== w.count) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("Result mismatch: expected %0d/%h/%0d, got %0d/%h/%0d",
                           w.status, w.entry_id, w.count,
                           rsp_status, rsp_entry_id, rsp_side_count);
            end
         end
      end
   end

   initial begin : watchdog
      #3000000;
      $display("Timed out with %0d results outstanding", pending_rsp.size());
      $display("CHECKS FAILED");
      $finish;
   end
endmodule
`default_nettype wire
